// File: hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// shared types and constants of the set similarity engine
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int NUM_SETS     = 64;
  localparam int SET_CAPACITY = 256;
  localparam int VALUE_BITS   = 30;
  localparam int ID_BITS      = $clog2(NUM_SETS);
  localparam int IDX_BITS     = $clog2(SET_CAPACITY);
  localparam int CNT_BITS     = IDX_BITS + 1;
  localparam int ADDR_BITS    = ID_BITS + IDX_BITS;
  localparam int NUM_BITS     = 20;
  localparam int DEN_BITS     = 11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_QUERY     = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SZA, S_SZB, S_NEXTA, S_WAITA, S_SCAN, S_CMP, S_DIV, S_DIVL, S_OUT
  } state_t;

endpackage

// File: hdl/set_similarity_engine.sv
// ----------------------------------------------------------------------------
// set_similarity_engine
// jaccard similarity of integer sets kept in one value memory
// ----------------------------------------------------------------------------
// scans: insert and query both run through the single read port of the value memory
//   and one shared compare unit; a query then runs a 20-step divider
// throughput: one item at a time, next item taken after the result is loaded
// reset: synchronous, clears all set sizes at once, no clearing pass
module set_similarity_engine import sse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // set_a[5:0], set_b[11:6], value[41:12], zero fill
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // common_count[8:0], union_count[18:9],
                                // percent_tenths[28:19], zero fill
  output logic [2:0]  m_tuser   // status
);

  logic [VALUE_BITS-1:0] mem [NUM_SETS*SET_CAPACITY];
  logic [CNT_BITS-1:0]   size_mem [NUM_SETS];
  logic [NUM_SETS-1:0]   size_valid;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic [CNT_BITS-1:0]   size_rdata;
  logic                  size_rvalid;

  state_t state, state_next;
  logic op, op_next;
  logic [ID_BITS-1:0] a_id, a_id_next, b_id, b_id_next;
  logic [VALUE_BITS-1:0] val, val_next, needle, needle_next;
  logic [CNT_BITS-1:0] na, na_next, nb, nb_next, i, i_next, j, j_next;
  logic [CNT_BITS-1:0] common, common_next;
  logic [9:0] uni, uni_next;
  logic [2:0] status, status_next;
  logic [NUM_BITS-1:0] num, num_next, quo, quo_next;
  logic [DEN_BITS-1:0] rem, rem_next;
  logic [4:0] cnt, cnt_next;
  logic out_valid, out_valid_next;
  logic [31:0] out_data, out_data_next;
  logic [2:0] out_user, out_user_next;

  logic [ADDR_BITS-1:0] rd_addr, wr_addr;
  logic wr_en, size_we;
  logic [ID_BITS-1:0] size_raddr;
  logic [ID_BITS-1:0] scan_set;
  logic [CNT_BITS-1:0] scan_n;
  logic [DEN_BITS:0] trial;
  logic [DEN_BITS-1:0] den;
  logic scan_done, found;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  assign scan_set = (op == OP_QUERY) ? b_id : a_id;
  assign scan_n   = (op == OP_QUERY) ? nb : na;
  assign den      = {uni, 1'b0};
  assign trial    = {rem, num[NUM_BITS-1]};
  assign wr_addr  = {a_id, na[IDX_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val;
    end
    mem_rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[a_id] <= na + CNT_BITS'(1);
    end
    size_rdata <= size_mem[size_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_valid  <= '0;
      size_rvalid <= 1'b0;
    end else begin
      if (size_we) begin
        size_valid[a_id] <= 1'b1;
      end
      size_rvalid <= size_valid[size_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      common    <= '0;
      uni       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      common    <= common_next;
      uni       <= uni_next;
    end
    op       <= op_next;
    a_id     <= a_id_next;
    b_id     <= b_id_next;
    val      <= val_next;
    needle   <= needle_next;
    na       <= na_next;
    nb       <= nb_next;
    i        <= i_next;
    j        <= j_next;
    status   <= status_next;
    num      <= num_next;
    quo      <= quo_next;
    rem      <= rem_next;
    cnt      <= cnt_next;
    out_data <= out_data_next;
    out_user <= out_user_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    a_id_next      = a_id;
    b_id_next      = b_id;
    val_next       = val;
    needle_next    = needle;
    na_next        = na;
    nb_next        = nb;
    i_next         = i;
    j_next         = j;
    common_next    = common;
    uni_next       = uni;
    status_next    = status;
    num_next       = num;
    quo_next       = quo;
    rem_next       = rem;
    cnt_next       = cnt;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    out_user_next  = out_user;
    rd_addr        = {scan_set, j[IDX_BITS-1:0]};
    size_raddr     = b_id;
    wr_en          = 1'b0;
    size_we        = 1'b0;
    scan_done      = 1'b0;
    found          = 1'b0;

    case (state)
      S_IDLE: begin
        size_raddr = s_tdata[ID_BITS-1:0];
        if (s_tvalid) begin
          op_next     = s_tuser;
          a_id_next   = s_tdata[ID_BITS-1:0];
          b_id_next   = s_tdata[2*ID_BITS-1:ID_BITS];
          val_next    = s_tdata[2*ID_BITS +: VALUE_BITS];
          common_next = '0;
          uni_next    = '0;
          quo_next    = '0;
          state_next  = S_SZA;
        end
      end
      S_SZA: begin
        na_next    = size_rvalid ? size_rdata : '0;
        state_next = S_SZB;
      end
      S_SZB: begin
        nb_next     = size_rvalid ? size_rdata : '0;
        needle_next = val;
        i_next      = '0;
        j_next      = '0;
        uni_next    = (op == OP_QUERY) ? 10'(size_rvalid ? size_rdata : '0) : '0;
        state_next  = (op == OP_QUERY) ? S_NEXTA : S_SCAN;
      end
      S_NEXTA: begin
        rd_addr = {a_id, i[IDX_BITS-1:0]};
        if (i == na) begin
          state_next = S_DIV;
        end else begin
          state_next = S_WAITA;
        end
      end
      S_WAITA: begin
        needle_next = mem_rdata;
        j_next      = '0;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (j == scan_n) begin
          scan_done = 1'b1;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (mem_rdata == needle) begin
          scan_done = 1'b1;
          found     = 1'b1;
        end else begin
          j_next     = j + CNT_BITS'(1);
          state_next = S_SCAN;
        end
      end
      S_DIV: begin
        // (common*2000 + union) / (2*union) gives half-up rounding
        num_next = NUM_BITS'(common) * NUM_BITS'(2000) + NUM_BITS'(uni);
        rem_next = '0;
        cnt_next = 5'(NUM_BITS - 1);
        if (uni == '0) begin
          status_next = ST_EMPTY;
          state_next  = S_OUT;
        end else begin
          state_next  = S_DIVL;
        end
      end
      S_DIVL: begin
        num_next = {num[NUM_BITS-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem_next = DEN_BITS'(trial - {1'b0, den});
          quo_next = {quo[NUM_BITS-2:0], 1'b1};
        end else begin
          rem_next = trial[DEN_BITS-1:0];
          quo_next = {quo[NUM_BITS-2:0], 1'b0};
        end
        cnt_next = cnt - 5'd1;
        if (cnt == '0) begin
          status_next = ST_QUERY;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_user_next  = status;
          out_data_next  = {3'b000, quo[9:0], uni, common};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (scan_done) begin
      if (op == OP_QUERY) begin
        if (found) begin
          common_next = common + CNT_BITS'(1);
        end else begin
          uni_next = uni + 10'd1;
        end
        i_next     = i + CNT_BITS'(1);
        state_next = S_NEXTA;
      end else begin
        if (found) begin
          status_next = ST_DUPLICATE;
        end else if (na == CNT_BITS'(SET_CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          wr_en       = 1'b1;
          size_we     = 1'b1;
          status_next = ST_INSERTED;
        end
        state_next = S_OUT;
      end
    end
  end

  a_insert_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_QUERY |-> m_tdata[28:19] == 10'd0)
    else $error("percent nonzero outside a finished query");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[28:19] <= 10'd1000)
    else $error("percent above 1000");

  a_common_le_union: assert property (@(posedge clk) disable iff (rst)
    10'(common) <= uni || op == OP_INSERT)
    else $error("common count above union count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready)
    else $error("ready while busy");

endmodule
